@@ src/cubic_pkg.sv @@
`default_nettype none

package cubic_pkg;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   // fixed field widths
   localparam int NEIGHBORS  = 4;
   localparam int LOAD_AW    = 14;
   localparam int SAMPLE_W   = 8;
   localparam int IDX_W      = 10;
   localparam int FRAC_BITS  = 16;
   localparam int CHAN_W     = 4;
   localparam int VAL_W      = 18;

   // datapath widths
   localparam int D_W        = SAMPLE_W + 1;
   localparam int COEF_W     = 14;
   localparam int H1_W       = 32;
   localparam int P_W        = H1_W + FRAC_BITS + 1;
   localparam int H2_W       = 32;
   localparam int Q_W        = H2_W + FRAC_BITS + 1;
   localparam int OUT_SH     = 2 * FRAC_BITS - 6;
   localparam int V_W        = Q_W - OUT_SH;

   // reciprocal shift for the pixel index wrap
   localparam int RECIP_SH   = 20;

   // rounding offsets, half up
   localparam logic signed [P_W-1:0] RND1 =
      {{(P_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [Q_W-1:0] RND2 =
      {{(Q_W-OUT_SH){1'b0}}, 1'b1, {(OUT_SH-1){1'b0}}};

   // saturation bounds
   localparam logic signed [V_W-1:0] V_MAX =
      {{(V_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
   localparam logic signed [V_W-1:0] V_MIN =
      {{(V_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX_OUT = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN_OUT = {1'b1, {(VAL_W-1){1'b0}}};

   // tag that travels with each channel through the pipeline
   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic              last;
      logic              row_end;
   } meta_type;

endpackage

`default_nettype wire

@@ src/cubic_ram.sv @@
`default_nettype none

module cubic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/cubic_interp_int8_16ch.sv @@
// Load transaction: the sample is written into all four store copies.
// Interpolate transaction: setup states QUOT, REM and BASE wrap the pixel indices and form
//   row bases, then one channel is issued per cycle while the output is not stalled.
// Throughput is set by the issue loop: four store copies give the four reads per channel.
// Results leave the output register at one per cycle unless stalled by rsp_ready.
// Reset clears control state and zero_point; the source store is not cleared.
`default_nettype none

module cubic_interp_int8_16ch
   import cubic_pkg::*;
#(
   parameter int CHANNELS      = 16,
   parameter int SOURCE_PIXELS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_operation,
   input  wire logic [LOAD_AW-1:0]         req_load_address,
   input  wire logic signed [SAMPLE_W-1:0] req_load_data,
   input  wire logic [IDX_W-1:0]           req_first_index,
   input  wire logic [IDX_W-1:0]           req_second_index,
   input  wire logic [IDX_W-1:0]           req_third_index,
   input  wire logic [IDX_W-1:0]           req_fourth_index,
   input  wire logic [FRAC_BITS-1:0]       req_fraction,
   input  wire logic                       req_final_pixel,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [CHAN_W-1:0]               rsp_channel,
   output logic signed [VAL_W-1:0]         rsp_value,
   output logic                            rsp_last,
   output logic                            rsp_row_end,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic signed [SAMPLE_W-1:0] csr_zero_point
);

   localparam int STORE_DEPTH = SOURCE_PIXELS * CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = $clog2(SOURCE_PIXELS);
   localparam int CNT_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);
   localparam logic [31:0] RECIP_C = 32'((1 << RECIP_SH) / SOURCE_PIXELS);
   localparam logic [31:0] SP_C    = 32'(SOURCE_PIXELS);
   localparam logic [31:0] CH_C    = 32'(CHANNELS);
   localparam logic [31:0] DEPTH_C = 32'(STORE_DEPTH);

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_QUOT  = 3'd1;
   localparam logic [ST_W-1:0] ST_REM   = 3'd2;
   localparam logic [ST_W-1:0] ST_BASE  = 3'd3;
   localparam logic [ST_W-1:0] ST_ISSUE = 3'd4;

   logic [ST_W-1:0]       state_ff, state_in;
   logic [CNT_W-1:0]      ch_cnt_ff, ch_cnt_in;
   logic [SAMPLE_W-1:0]   zp_ff;

   logic [IDX_W-1:0]      idx_ff  [NEIGHBORS];
   logic [IDX_W-1:0]      quot_ff [NEIGHBORS];
   logic [IDX_W-1:0]      quot_in [NEIGHBORS];
   logic [PIX_W-1:0]      pix_ff  [NEIGHBORS];
   logic [PIX_W-1:0]      pix_in  [NEIGHBORS];
   logic [ADDR_W-1:0]     base_ff [NEIGHBORS];
   logic [ADDR_W-1:0]     base_in [NEIGHBORS];
   logic [FRAC_BITS-1:0]  frac_ff;
   logic                  final_ff;

   logic                  req_fire;
   logic                  issuing;
   logic                  adv;
   logic                  store_wr;
   logic [ADDR_W-1:0]     store_wr_addr;
   logic [ADDR_W-1:0]     rd_addr [NEIGHBORS];
   logic [SAMPLE_W-1:0]   ram_q   [NEIGHBORS];
   meta_type              issue_meta;

   // pipeline valids
   logic                  vld_rd_ff, vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff;
   logic                  rsp_valid_ff;

   // pipeline payload
   meta_type              meta_rd_ff, meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff, meta6_ff;
   logic [FRAC_BITS-1:0]  frac_rd_ff, frac1_ff, frac2_ff, frac3_ff, frac4_ff;
   logic signed [COEF_W-1:0] a4_ff, b4_ff, c4_ff, e4_ff;
   logic signed [COEF_W-1:0] a4_in, b4_in, c4_in, e4_in;
   logic signed [COEF_W-1:0] c4_2_ff, c4_3_ff;
   logic signed [COEF_W-1:0] e4_2_ff, e4_3_ff, e4_4_ff, e4_5_ff;
   logic signed [H1_W-1:0]   h1_ff, h1_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [H2_W-1:0]   h2_ff, h2_in;
   logic signed [Q_W-1:0]    q_ff, q_in;
   logic signed [Q_W-1:0]    h3_ff, h3_in;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   meta_type                 out_meta_ff;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign issuing   = (state_ff == ST_ISSUE);
   assign adv       = !rsp_valid_ff || rsp_ready;

   // load path: every store copy takes the same write
   assign store_wr = req_fire && (req_operation == OP_LOAD) &&
                     ({{(32-LOAD_AW){1'b0}}, req_load_address} < DEPTH_C);
   assign store_wr_addr = ADDR_W'(req_load_address);

   // index wrap and row base, one step per setup cycle
   always_comb begin
      logic [31:0] idx32;
      logic [31:0] prod;
      logic [31:0] qsp;
      logic [31:0] rem;
      logic [31:0] rem2;
      logic [31:0] pbase;
      for (int i = 0; i < NEIGHBORS; i++) begin
         idx32      = {{(32-IDX_W){1'b0}}, idx_ff[i]};
         prod       = idx32 * RECIP_C;
         quot_in[i] = prod[RECIP_SH +: IDX_W];
         qsp        = {{(32-IDX_W){1'b0}}, quot_ff[i]} * SP_C;
         rem        = idx32 - qsp;
         rem2       = (rem >= SP_C) ? (rem - SP_C) : rem;
         pix_in[i]  = rem2[PIX_W-1:0];
         pbase      = {{(32-PIX_W){1'b0}}, pix_ff[i]} * CH_C;
         base_in[i] = pbase[ADDR_W-1:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      ch_cnt_in = ch_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_operation == OP_INTERP)) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT:  state_in = ST_REM;
         ST_REM:   state_in = ST_BASE;
         ST_BASE: begin
            state_in  = ST_ISSUE;
            ch_cnt_in = '0;
         end
         ST_ISSUE: begin
            if (adv) begin
               if (ch_cnt_ff == LAST_CH) begin
                  state_in  = ST_IDLE;
                  ch_cnt_in = '0;
               end else begin
                  ch_cnt_in = ch_cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_cnt_ff    <= '0;
         zp_ff        <= '0;
         vld_rd_ff    <= 1'b0;
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         vld4_ff      <= 1'b0;
         vld5_ff      <= 1'b0;
         vld6_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ch_cnt_ff <= ch_cnt_in;
         if (csr_valid) begin
            zp_ff <= csr_zero_point;
         end
         if (adv) begin
            vld_rd_ff    <= issuing;
            vld1_ff      <= vld_rd_ff;
            vld2_ff      <= vld1_ff;
            vld3_ff      <= vld2_ff;
            vld4_ff      <= vld3_ff;
            vld5_ff      <= vld4_ff;
            vld6_ff      <= vld5_ff;
            rsp_valid_ff <= vld6_ff;
         end
      end
   end

   // captured interpolate transaction and setup results
   always_ff @(posedge clock) begin
      if (req_fire && (req_operation == OP_INTERP)) begin
         idx_ff[0] <= req_first_index;
         idx_ff[1] <= req_second_index;
         idx_ff[2] <= req_third_index;
         idx_ff[3] <= req_fourth_index;
         frac_ff   <= req_fraction;
         final_ff  <= req_final_pixel;
      end
      quot_ff <= quot_in;
      pix_ff  <= pix_in;
      base_ff <= base_in;
   end

   // channel tag for the issue slot
   always_comb begin
      issue_meta.channel = CHAN_W'(ch_cnt_ff);
      issue_meta.last    = (ch_cnt_ff == LAST_CH);
      issue_meta.row_end = (ch_cnt_ff == LAST_CH) && final_ff;
   end

   // four store copies, one per neighbour
   for (genvar g = 0; g < NEIGHBORS; g++) begin : g_store
      assign rd_addr[g] = base_ff[g] + ADDR_W'(ch_cnt_ff);

      cubic_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (STORE_DEPTH)
      ) u_store (
         .clock   (clock),
         .wr_en   (store_wr),
         .wr_addr (store_wr_addr),
         .wr_data (req_load_data),
         .rd_en   (adv && issuing),
         .rd_addr (rd_addr[g]),
         .rd_data (ram_q[g])
      );
   end

   // stage 1: remove zero point, form coefficients times four
   always_comb begin
      logic signed [D_W-1:0]    d  [NEIGHBORS];
      logic signed [COEF_W-1:0] dx [NEIGHBORS];
      logic signed [COEF_W-1:0] diff;
      for (int i = 0; i < NEIGHBORS; i++) begin
         d[i]  = $signed({ram_q[i][SAMPLE_W-1], ram_q[i]}) -
                 $signed({zp_ff[SAMPLE_W-1], zp_ff});
         dx[i] = {{(COEF_W-D_W){d[i][D_W-1]}}, d[i]};
      end
      diff  = dx[2] - dx[0];
      a4_in = (dx[1] <<< 2) + dx[1] - (dx[2] <<< 2) - dx[2]
            + (dx[3] <<< 1) + dx[3] - (dx[0] <<< 1) - dx[0];
      b4_in = (dx[0] <<< 2) + (dx[0] <<< 1) - (dx[1] <<< 3) - dx[1]
            + (dx[2] <<< 2) + (dx[2] <<< 1) - (dx[3] <<< 1) - dx[3];
      c4_in = (diff <<< 1) + diff;
      e4_in = dx[1] <<< 2;
   end

   // stage 2: h1 = a4 * f + b4 * 2^F
   always_comb begin
      logic signed [H1_W-1:0] a4h;
      logic signed [H1_W-1:0] b4h;
      logic signed [H1_W-1:0] fh;
      a4h   = {{(H1_W-COEF_W){a4_ff[COEF_W-1]}}, a4_ff};
      b4h   = {{(H1_W-COEF_W){b4_ff[COEF_W-1]}}, b4_ff};
      fh    = {{(H1_W-FRAC_BITS){1'b0}}, frac1_ff};
      h1_in = a4h * fh + (b4h <<< FRAC_BITS);
   end

   // stage 3: h1 * f
   always_comb begin
      logic signed [P_W-1:0] h1p;
      logic signed [P_W-1:0] fp;
      h1p  = {{(P_W-H1_W){h1_ff[H1_W-1]}}, h1_ff};
      fp   = {{(P_W-FRAC_BITS){1'b0}}, frac2_ff};
      p_in = h1p * fp;
   end

   // stage 4: round back to F bits and add c4 * 2^F
   always_comb begin
      logic signed [P_W-1:0]  pr;
      logic signed [H2_W-1:0] pr_hi;
      logic signed [H2_W-1:0] c4h;
      pr    = p_ff + RND1;
      pr_hi = pr[FRAC_BITS +: H2_W];
      c4h   = {{(H2_W-COEF_W){c4_3_ff[COEF_W-1]}}, c4_3_ff};
      h2_in = pr_hi + (c4h <<< FRAC_BITS);
   end

   // stage 5: h2 * f
   always_comb begin
      logic signed [Q_W-1:0] h2q;
      logic signed [Q_W-1:0] fq;
      h2q  = {{(Q_W-H2_W){h2_ff[H2_W-1]}}, h2_ff};
      fq   = {{(Q_W-FRAC_BITS){1'b0}}, frac4_ff};
      q_in = h2q * fq;
   end

   // stage 6: add d1 term and the rounding offset
   always_comb begin
      logic signed [Q_W-1:0] e4q;
      e4q   = {{(Q_W-COEF_W){e4_5_ff[COEF_W-1]}}, e4_5_ff};
      h3_in = q_ff + (e4q <<< (2 * FRAC_BITS)) + RND2;
   end

   // output stage: drop fraction bits and saturate
   always_comb begin
      logic signed [V_W-1:0] v;
      v = h3_ff[Q_W-1:OUT_SH];
      if (v > V_MAX) begin
         value_in = VAL_MAX_OUT;
      end else if (v < V_MIN) begin
         value_in = VAL_MIN_OUT;
      end else begin
         value_in = v[VAL_W-1:0];
      end
   end

   // pipeline payload, frozen while the output is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         meta_rd_ff  <= issue_meta;
         frac_rd_ff  <= frac_ff;

         meta1_ff    <= meta_rd_ff;
         frac1_ff    <= frac_rd_ff;
         a4_ff       <= a4_in;
         b4_ff       <= b4_in;
         c4_ff       <= c4_in;
         e4_ff       <= e4_in;

         meta2_ff    <= meta1_ff;
         frac2_ff    <= frac1_ff;
         h1_ff       <= h1_in;
         c4_2_ff     <= c4_ff;
         e4_2_ff     <= e4_ff;

         meta3_ff    <= meta2_ff;
         frac3_ff    <= frac2_ff;
         p_ff        <= p_in;
         c4_3_ff     <= c4_2_ff;
         e4_3_ff     <= e4_2_ff;

         meta4_ff    <= meta3_ff;
         frac4_ff    <= frac3_ff;
         h2_ff       <= h2_in;
         e4_4_ff     <= e4_3_ff;

         meta5_ff    <= meta4_ff;
         q_ff        <= q_in;
         e4_5_ff     <= e4_4_ff;

         meta6_ff    <= meta5_ff;
         h3_ff       <= h3_in;

         out_meta_ff <= meta6_ff;
         value_ff    <= value_in;
      end
   end

   // result ports
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = out_meta_ff.channel;
   assign rsp_value   = value_ff;
   assign rsp_last    = out_meta_ff.last;
   assign rsp_row_end = out_meta_ff.row_end;

endmodule

`default_nettype wire
